// ----- hw/rtl/qgsv_pkg.sv -----
// ----------------------------------------------------------------------------
// qgsv_pkg
// Shared constants, register indexes and the command/status bundles that
// join the controller and the datapath of the state vector gate block.
// ----------------------------------------------------------------------------
package qgsv_pkg;

    localparam int MAX_QUBITS = 11;
    localparam int AMP_WIDTH  = 16;
    localparam int FRAC_BITS  = 14;
    localparam int IDX_W      = MAX_QUBITS;
    localparam int DEPTH      = 1 << MAX_QUBITS;
    localparam int ENTRY_W    = 2 * AMP_WIDTH;
    localparam int PROD_W     = 2 * AMP_WIDTH;
    localparam int SUM_W      = PROD_W + 2;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int QCNT_W     = 4;
    localparam int CTRLQ_W    = 5;

    // Control qubit value that selects a plain single-qubit gate.
    localparam logic [CTRLQ_W-1:0] CTRL_NONE = '1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GATE_00   = 3'd0,
        CFG_GATE_01   = 3'd1,
        CFG_GATE_10   = 3'd2,
        CFG_GATE_11   = 3'd3,
        CFG_CONTROL_Q = 3'd4,
        CFG_TARGET_Q  = 3'd5,
        CFG_QUBIT_CNT = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic accept;    // take the input beat (write or read)
        logic mul_en;    // register the partial products
        logic sum_en;    // register the complex sums
        logic out_load;  // load the output register
    } t_dp_cmd;

    typedef struct packed {
        logic is_read;      // the offered beat is a read
        logic out_blocked;  // output register full and stalled
    } t_dp_stat;

endpackage

// ----- hw/rtl/qubit_gate_state_vector.sv -----
// ----------------------------------------------------------------------------
// qubit_gate_state_vector
// Stored complex state vector with a configurable single-qubit gate or CNOT
// applied on readout.
// ----------------------------------------------------------------------------
// A write beat stores one Q2.14 amplitude; the block can take another beat
// in the next cycle. For a read beat, both amplitudes of the pair come from
// the memory's two read ports in the accepting cycle, then the eight partial
// products are registered, then the complex sums, and the scaled and
// saturated sums (for CNOT, the own or mate amplitude) go into the output
// register. The block takes its next beat in the cycle after the output
// load and takes no new beat while a read is in progress. A finished
// result waits in the output register while the next beat is accepted; if
// the previous result is still stalled, the block holds in its last step
// until the register frees. Out-of-range reads give a zero amplitude with
// range_error set. Reading an amplitude that was never written returns
// undefined data. The configuration port may be written only while the
// block is idle.
// ----------------------------------------------------------------------------
module qubit_gate_state_vector
    import qgsv_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]            i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_command,
    input  logic [IDX_W-1:0]            i_amp_index,
    input  logic signed [AMP_WIDTH-1:0] i_amp_real,
    input  logic signed [AMP_WIDTH-1:0] i_amp_imag,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [IDX_W-1:0]            o_result_index,
    output logic signed [AMP_WIDTH-1:0] o_out_real,
    output logic signed [AMP_WIDTH-1:0] o_out_imag,
    output logic                        o_range_error
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    qgsv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    qgsv_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_command),
        .i_amp_index    (i_amp_index),
        .i_amp_real     (i_amp_real),
        .i_amp_imag     (i_amp_imag),
        .i_out_stall    (i_out_stall),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .o_result_index (o_result_index),
        .o_out_real     (o_out_real),
        .o_out_imag     (o_out_imag),
        .o_range_error  (o_range_error)
    );

endmodule

// ----- hw/rtl/qgsv_ctrl.sv -----
// ----------------------------------------------------------------------------
// qgsv_ctrl
// Sequencer for one read: memory read, products, sums, then output load.
// Writes complete in the accepting cycle.
// ----------------------------------------------------------------------------
module qgsv_ctrl
    import qgsv_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_stall,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_SUM  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_in_stall     = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_stat.is_read) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_en = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!i_stat.out_blocked) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hw/rtl/qgsv_dp.sv -----
// ----------------------------------------------------------------------------
// qgsv_dp
// Datapath: configuration registers, amplitude memory with two read ports,
// complex multiply, sum, scale and saturate, and the output register.
// ----------------------------------------------------------------------------
module qgsv_dp
    import qgsv_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]            i_cfg_data,
    input  logic                        i_command,
    input  logic [IDX_W-1:0]            i_amp_index,
    input  logic signed [AMP_WIDTH-1:0] i_amp_real,
    input  logic signed [AMP_WIDTH-1:0] i_amp_imag,
    input  logic                        i_out_stall,
    input  t_dp_cmd                     i_cmd,
    output t_dp_stat                    o_stat,
    output logic                        o_out_valid,
    output logic [IDX_W-1:0]            o_result_index,
    output logic signed [AMP_WIDTH-1:0] o_out_real,
    output logic signed [AMP_WIDTH-1:0] o_out_imag,
    output logic                        o_range_error
);

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'd1 << (AMP_WIDTH - 1)) - 64'd1);
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    // Floor shift by the fraction width, then clip to the amplitude range.
    function automatic logic [AMP_WIDTH-1:0] scale_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] s;
        s = v >>> FRAC_BITS;
        if (s > SAT_HI) begin
            s = SAT_HI;
        end else if (s < SAT_LO) begin
            s = SAT_LO;
        end
        return s[AMP_WIDTH-1:0];
    endfunction

    // Configuration registers.
    logic [CFG_W-1:0]   r_g00, r_g01, r_g10, r_g11;
    logic [CTRLQ_W-1:0] r_ctrl_q;
    logic [QCNT_W-1:0]  r_tgt_q;
    logic [QCNT_W-1:0]  r_qcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g00    <= 32'h4000_0000;
            r_g01    <= '0;
            r_g10    <= '0;
            r_g11    <= 32'h4000_0000;
            r_ctrl_q <= CTRL_NONE;
            r_tgt_q  <= '0;
            r_qcnt   <= QCNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GATE_00:   r_g00    <= i_cfg_data;
                CFG_GATE_01:   r_g01    <= i_cfg_data;
                CFG_GATE_10:   r_g10    <= i_cfg_data;
                CFG_GATE_11:   r_g11    <= i_cfg_data;
                CFG_CONTROL_Q: r_ctrl_q <= i_cfg_data[CTRLQ_W-1:0];
                CFG_TARGET_Q:  r_tgt_q  <= i_cfg_data[QCNT_W-1:0];
                CFG_QUBIT_CNT: r_qcnt   <= i_cfg_data[QCNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Range check and pairing of the offered index.
    logic             use_ctrl;
    logic             range_ok;
    logic [IDX_W-1:0] mate_idx;
    logic             pick_mate;

    always_comb begin
        use_ctrl = (r_ctrl_q != CTRL_NONE);
        range_ok = (r_qcnt != '0) && (r_qcnt <= QCNT_W'(MAX_QUBITS)) && (r_tgt_q < r_qcnt);
        if (use_ctrl) begin
            range_ok = range_ok && !r_ctrl_q[CTRLQ_W-1]
                       && (r_ctrl_q[CTRLQ_W-2:0] < r_qcnt);
        end
        range_ok  = range_ok && ((i_amp_index >> r_qcnt) == '0);
        mate_idx  = i_amp_index ^ (IDX_W'(1) << r_tgt_q);
        pick_mate = (r_ctrl_q[CTRLQ_W-2:0] == r_tgt_q)
                    || i_amp_index[r_ctrl_q[CTRLQ_W-2:0]];
    end

    // Amplitude memory: one write port, two registered read ports.
    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_own;
    logic [ENTRY_W-1:0] r_mate;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            if (i_command == CMD_WRITE) begin
                r_mem[i_amp_index] <= {i_amp_real, i_amp_imag};
            end else begin
                r_own  <= r_mem[i_amp_index];
                r_mate <= r_mem[mate_idx];
            end
        end
    end

    // Per-read context captured at accept.
    logic [IDX_W-1:0] r_idx;
    logic             r_err;
    logic             r_cnot;
    logic             r_swap;
    logic             r_hi_half;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_command == CMD_READ) begin
            r_idx     <= i_amp_index;
            r_err     <= !range_ok;
            r_cnot    <= use_ctrl;
            r_swap    <= pick_mate;
            r_hi_half <= i_amp_index[r_tgt_q[$clog2(IDX_W)-1:0]];
        end
    end

    // Complex products: gs * own + gm * mate.
    logic [CFG_W-1:0]            gs, gm;
    logic signed [AMP_WIDTH-1:0] gs_re, gs_im, gm_re, gm_im;
    logic signed [AMP_WIDTH-1:0] own_re, own_im, mate_re, mate_im;
    logic signed [PROD_W-1:0]    r_prod [8];

    always_comb begin
        gs      = r_hi_half ? r_g11 : r_g00;
        gm      = r_hi_half ? r_g10 : r_g01;
        gs_re   = gs[CFG_W-1 -: AMP_WIDTH];
        gs_im   = gs[AMP_WIDTH-1:0];
        gm_re   = gm[CFG_W-1 -: AMP_WIDTH];
        gm_im   = gm[AMP_WIDTH-1:0];
        own_re  = r_own[ENTRY_W-1 -: AMP_WIDTH];
        own_im  = r_own[AMP_WIDTH-1:0];
        mate_re = r_mate[ENTRY_W-1 -: AMP_WIDTH];
        mate_im = r_mate[AMP_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod[0] <= gs_re * own_re;
            r_prod[1] <= gs_im * own_im;
            r_prod[2] <= gm_re * mate_re;
            r_prod[3] <= gm_im * mate_im;
            r_prod[4] <= gs_re * own_im;
            r_prod[5] <= gs_im * own_re;
            r_prod[6] <= gm_re * mate_im;
            r_prod[7] <= gm_im * mate_re;
        end
    end

    logic signed [SUM_W-1:0] r_sum_re;
    logic signed [SUM_W-1:0] r_sum_im;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_en) begin
            r_sum_re <= SUM_W'(r_prod[0]) - SUM_W'(r_prod[1])
                      + SUM_W'(r_prod[2]) - SUM_W'(r_prod[3]);
            r_sum_im <= SUM_W'(r_prod[4]) + SUM_W'(r_prod[5])
                      + SUM_W'(r_prod[6]) + SUM_W'(r_prod[7]);
        end
    end

    // Output selection and register.
    logic [AMP_WIDTH-1:0] res_re;
    logic [AMP_WIDTH-1:0] res_im;

    always_comb begin
        priority if (r_err) begin
            res_re = '0;
            res_im = '0;
        end else if (r_cnot) begin
            res_re = r_swap ? mate_re : own_re;
            res_im = r_swap ? mate_im : own_im;
        end else begin
            res_re = scale_sat(r_sum_re);
            res_im = scale_sat(r_sum_im);
        end
    end

    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_result_index <= r_idx;
            o_out_real     <= res_re;
            o_out_imag     <= res_im;
            o_range_error  <= r_err;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_stat.is_read     = (i_command == CMD_READ);
    assign o_stat.out_blocked = r_out_valid && i_out_stall;

endmodule
